>>> design/rxfhf_pkg.sv
// Shared types and constants for the receive frame header filter.
`default_nettype none

package rxfhf_pkg;

   // Parser phase within one frame
   typedef enum logic [2:0] {
      PH_LENGTH  = 3'd0,
      PH_TARGET  = 3'd1,
      PH_SENDER  = 3'd2,
      PH_CONTROL = 3'd3,
      PH_PAYLOAD = 3'd4
   } phase_type;

   // Result kind codes
   typedef enum logic [1:0] {
      KIND_ACCEPT  = 2'd0,
      KIND_REJECT  = 2'd1,
      KIND_PAYLOAD = 2'd2
   } kind_type;

   // Configuration register indexes (byte address / 4)
   localparam logic [1:0] REG_NODE_ADDRESS      = 2'd0;
   localparam logic [1:0] REG_BROADCAST_ADDRESS = 2'd1;
   localparam logic [1:0] REG_SPY_MODE          = 2'd2;

   localparam int unsigned ADDR_W = 10;
   localparam logic [ADDR_W-1:0] NODE_ADDRESS_RESET      = 10'd0;
   localparam logic [ADDR_W-1:0] BROADCAST_ADDRESS_RESET = 10'd255;

   // Control byte fields
   localparam int unsigned CTL_ACK_SENT_BIT = 7;
   localparam int unsigned CTL_ACK_REQ_BIT  = 6;
   localparam logic [7:0] TARGET_HI_MASK = 8'h0C;
   localparam logic [7:0] SENDER_HI_MASK = 8'h03;

   // Input beat
   typedef struct packed {
      logic [7:0] fifo_byte;
      logic       frame_start;
   } req_beat_type;

   // Result beat
   typedef struct packed {
      kind_type          kind;
      logic [ADDR_W-1:0] target_id;
      logic [ADDR_W-1:0] sender_id;
      logic              is_ack;
      logic              wants_ack;
      logic [5:0]        data_length;
      logic [7:0]        data_byte;
      logic              last;
   } rsp_beat_type;

endpackage

`default_nettype wire

>>> design/radio_rx_frame_header_filter.sv
// Receive frame header filter: parses FIFO bytes into header verdicts and payload beats.
//
// Input channel (req_): one received byte per beat, with frame_start marking the
// length byte of a new frame. A beat is taken at a clock edge with req_valid high
// and req_stall low.
// Result channel (rsp_): header verdicts (accepted or rejected) on the control
// byte, then payload bytes of accepted frames with last on the final one.
// Length, target and sender bytes, stray bytes and dropped payload yield no result.
// A result enters the output register when its beat is taken, or the skid register
// if the output is held. Throughput: one byte per cycle while req_stall is low; the
// parser state updates in a single registered pass per byte.
// When the receiver stalls, the result register holds and one further result
// parks in a skid register; req_stall rises only while that skid register is full.
// Reset (synchronous, active high) returns the parser to expecting a length byte,
// empties both result registers and loads the register defaults (node 0,
// broadcast 255, spy mode off).
// Configuration (csr_): APB-style, registers at byte addresses 0, 4 and 8; write
// them only while the block is idle.
`default_nettype none

module radio_rx_frame_header_filter #(
   parameter int unsigned MAX_FRAME_LENGTH = 66
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // input channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire rxfhf_pkg::req_beat_type req_data,
   // result channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rxfhf_pkg::rsp_beat_type    rsp_data,
   // configuration port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [3:0]            csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   localparam int unsigned LenW = $clog2(MAX_FRAME_LENGTH + 1);
   localparam logic [7:0]      LenLimitByte = 8'(MAX_FRAME_LENGTH);
   localparam logic [LenW-1:0] LenLimit     = LenW'(MAX_FRAME_LENGTH);
   localparam logic [LenW-1:0] HeaderLen    = LenW'(3);
   localparam logic [LenW-1:0] OneLeft      = LenW'(1);

   // ---------------------------------------------------------------- config
   logic [rxfhf_pkg::ADDR_W-1:0] node_address_ff;
   logic [rxfhf_pkg::ADDR_W-1:0] broadcast_address_ff;
   logic                         spy_mode_ff;
   logic                         csr_write;
   logic [1:0]                   csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   // Write the addressed register
   always_ff @(posedge clock) begin
      if (reset) begin
         node_address_ff      <= rxfhf_pkg::NODE_ADDRESS_RESET;
         broadcast_address_ff <= rxfhf_pkg::BROADCAST_ADDRESS_RESET;
         spy_mode_ff          <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            rxfhf_pkg::REG_NODE_ADDRESS: begin
               node_address_ff <= csr_pwdata[rxfhf_pkg::ADDR_W-1:0];
            end
            rxfhf_pkg::REG_BROADCAST_ADDRESS: begin
               broadcast_address_ff <= csr_pwdata[rxfhf_pkg::ADDR_W-1:0];
            end
            rxfhf_pkg::REG_SPY_MODE: begin
               spy_mode_ff <= csr_pwdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // Return the addressed register
   always_comb begin
      case (csr_index)
         rxfhf_pkg::REG_NODE_ADDRESS:      csr_prdata = 32'(node_address_ff);
         rxfhf_pkg::REG_BROADCAST_ADDRESS: csr_prdata = 32'(broadcast_address_ff);
         rxfhf_pkg::REG_SPY_MODE:          csr_prdata = 32'(spy_mode_ff);
         default:                          csr_prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------- parser
   rxfhf_pkg::phase_type phase_ff, phase_in;
   logic [LenW-1:0]      frame_length_ff, frame_length_in;
   logic [LenW-1:0]      bytes_left_ff, bytes_left_in;
   logic [7:0]           target_low_ff, target_low_in;
   logic [7:0]           sender_low_ff, sender_low_in;
   logic                 dropping_ff, dropping_in;

   logic                         req_take;
   logic [7:0]                   rx_byte;
   logic [rxfhf_pkg::ADDR_W-1:0] target_id;
   logic [rxfhf_pkg::ADDR_W-1:0] sender_id;
   logic                         long_enough;
   logic                         frame_ok;
   logic [LenW-1:0]              data_len;
   logic                         final_byte;

   assign req_take    = req_valid && !req_stall;
   assign rx_byte     = req_data.fifo_byte;
   assign target_id   = {rx_byte[3:2] & rxfhf_pkg::TARGET_HI_MASK[3:2], target_low_ff};
   assign sender_id   = {rx_byte[1:0] & rxfhf_pkg::SENDER_HI_MASK[1:0], sender_low_ff};
   assign long_enough = frame_length_ff >= HeaderLen;
   assign frame_ok    = (spy_mode_ff || target_id == node_address_ff
                         || target_id == broadcast_address_ff) && long_enough;
   assign data_len    = long_enough ? frame_length_ff - HeaderLen : '0;
   assign final_byte  = bytes_left_ff <= OneLeft;

   // Next parser state for the byte on the input
   always_comb begin
      phase_in        = phase_ff;
      frame_length_in = frame_length_ff;
      bytes_left_in   = bytes_left_ff;
      target_low_in   = target_low_ff;
      sender_low_in   = sender_low_ff;
      dropping_in     = dropping_ff;
      if (req_data.frame_start) begin
         frame_length_in = (rx_byte > LenLimitByte) ? LenLimit : LenW'(rx_byte);
         bytes_left_in   = '0;
         dropping_in     = 1'b0;
         phase_in        = rxfhf_pkg::PH_TARGET;
      end else begin
         case (phase_ff)
            rxfhf_pkg::PH_LENGTH: begin
            end
            rxfhf_pkg::PH_TARGET: begin
               target_low_in = rx_byte;
               phase_in      = rxfhf_pkg::PH_SENDER;
            end
            rxfhf_pkg::PH_SENDER: begin
               sender_low_in = rx_byte;
               phase_in      = rxfhf_pkg::PH_CONTROL;
            end
            rxfhf_pkg::PH_CONTROL: begin
               bytes_left_in = data_len;
               if (data_len == '0) begin
                  phase_in    = rxfhf_pkg::PH_LENGTH;
                  dropping_in = 1'b0;
               end else begin
                  phase_in    = rxfhf_pkg::PH_PAYLOAD;
                  dropping_in = !frame_ok;
               end
            end
            rxfhf_pkg::PH_PAYLOAD: begin
               if (final_byte) begin
                  bytes_left_in = '0;
                  phase_in      = rxfhf_pkg::PH_LENGTH;
                  dropping_in   = 1'b0;
               end else begin
                  bytes_left_in = bytes_left_ff - OneLeft;
               end
            end
            default: begin
               phase_in = rxfhf_pkg::PH_LENGTH;
            end
         endcase
      end
   end

   // Advance the parser on each taken beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= rxfhf_pkg::PH_LENGTH;
         frame_length_ff <= '0;
         bytes_left_ff   <= '0;
         target_low_ff   <= '0;
         sender_low_ff   <= '0;
         dropping_ff     <= 1'b0;
      end else if (req_take) begin
         phase_ff        <= phase_in;
         frame_length_ff <= frame_length_in;
         bytes_left_ff   <= bytes_left_in;
         target_low_ff   <= target_low_in;
         sender_low_ff   <= sender_low_in;
         dropping_ff     <= dropping_in;
      end
   end

   // ---------------------------------------------------------------- result
   logic                   result_hit;
   rxfhf_pkg::rsp_beat_type result;

   // Build the result for the byte on the input
   always_comb begin
      result     = '0;
      result_hit = 1'b0;
      if (!req_data.frame_start) begin
         case (phase_ff)
            rxfhf_pkg::PH_CONTROL: begin
               result_hit       = 1'b1;
               result.target_id = target_id;
               result.sender_id = sender_id;
               if (frame_ok) begin
                  result.kind        = rxfhf_pkg::KIND_ACCEPT;
                  result.is_ack      = rx_byte[rxfhf_pkg::CTL_ACK_SENT_BIT];
                  result.wants_ack   = rx_byte[rxfhf_pkg::CTL_ACK_REQ_BIT];
                  result.data_length = 6'(data_len);
                  result.last        = (data_len == '0);
               end else begin
                  result.kind = rxfhf_pkg::KIND_REJECT;
                  result.last = 1'b1;
               end
            end
            rxfhf_pkg::PH_PAYLOAD: begin
               result_hit       = !dropping_ff;
               result.kind      = rxfhf_pkg::KIND_PAYLOAD;
               result.data_byte = rx_byte;
               result.last      = final_byte;
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- output
   logic                    out_valid_ff;
   rxfhf_pkg::rsp_beat_type out_data_ff;
   logic                    skid_valid_ff;
   rxfhf_pkg::rsp_beat_type skid_data_ff;
   logic                    push;
   logic                    pop;

   assign push      = req_take && result_hit;
   assign pop       = out_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Hold the output beat while stalled; park one more beat in the skid register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= push;
         end else begin
            out_valid_ff  <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_data_ff  <= skid_data_ff;
            skid_data_ff <= result;
         end else begin
            out_data_ff  <= result;
         end
      end else if (push) begin
         skid_data_ff <= result;
      end
   end

   // ---------------------------------------------------------------- checks
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while output register empty");

   a_start_to_target: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_data.frame_start) |=> phase_ff == rxfhf_pkg::PH_TARGET)
      else $error("frame start did not restart the header parse");

   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == rxfhf_pkg::PH_PAYLOAD |-> bytes_left_ff != '0)
      else $error("payload phase with no bytes left");

   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind == rxfhf_pkg::KIND_PAYLOAD)
      |-> (rsp_data.target_id == '0 && rsp_data.data_length == '0))
      else $error("payload beat carries header fields");

   a_no_result_dropping: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == rxfhf_pkg::PH_PAYLOAD && dropping_ff) |-> !result_hit)
      else $error("result raised for a dropped frame");

endmodule

`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for the receive frame header filter.
`timescale 1ns / 100ps

module testbench;

   localparam int MAX_LEN     = 66;
   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE      = 4;
   localparam int PHASE_BYTES = 175;

   // Predicts header verdicts and payload beats and holds them until they arrive
   class frame_parse_board;
      rxfhf_pkg::rsp_beat_type awaited[$];
      int unsigned          faults;
      logic [9:0]           node_id;
      logic [9:0]           bcast_id;
      logic                 spy_on;
      rxfhf_pkg::phase_type stage;
      logic [6:0]           frame_len;
      logic [6:0]           remaining;
      logic [7:0]           target_lo;
      logic [7:0]           sender_lo;
      logic                 discarding;

      function new();
         node_id    = rxfhf_pkg::NODE_ADDRESS_RESET;
         bcast_id   = rxfhf_pkg::BROADCAST_ADDRESS_RESET;
         spy_on     = 1'b0;
         stage      = rxfhf_pkg::PH_LENGTH;
         frame_len  = '0;
         remaining  = '0;
         target_lo  = '0;
         sender_lo  = '0;
         discarding = 1'b0;
         faults     = 0;
      endfunction

      function void write_register(logic [1:0] idx, logic [31:0] value);
         case (idx)
            rxfhf_pkg::REG_NODE_ADDRESS:      node_id  = value[9:0];
            rxfhf_pkg::REG_BROADCAST_ADDRESS: bcast_id = value[9:0];
            rxfhf_pkg::REG_SPY_MODE:          spy_on   = value[0];
            default: ;
         endcase
      endfunction

      function void parse_byte(rxfhf_pkg::req_beat_type beat);
         rxfhf_pkg::rsp_beat_type verdict;
         logic [7:0]   b;
         logic [9:0]   tgt;
         logic [9:0]   snd;
         logic [6:0]   dlen;
         logic         ok;
         logic         fin;
         logic         was_discarding;
         b = beat.fifo_byte;
         verdict = '0;
         // A length byte always restarts the frame, abandoning any frame in progress
         if (beat.frame_start) begin
            frame_len  = (b > 8'(MAX_LEN)) ? 7'(MAX_LEN) : b[6:0];
            remaining  = '0;
            discarding = 1'b0;
            stage      = rxfhf_pkg::PH_TARGET;
            return;
         end
         case (stage)
            rxfhf_pkg::PH_TARGET: begin
               target_lo = b;
               stage = rxfhf_pkg::PH_SENDER;
            end
            rxfhf_pkg::PH_SENDER: begin
               sender_lo = b;
               stage = rxfhf_pkg::PH_CONTROL;
            end
            rxfhf_pkg::PH_CONTROL: begin
               tgt  = {2'b00, target_lo} | ({2'b00, b & rxfhf_pkg::TARGET_HI_MASK} << 6);
               snd  = {2'b00, sender_lo} | ({2'b00, b & rxfhf_pkg::SENDER_HI_MASK} << 8);
               ok   = (spy_on || tgt == node_id || tgt == bcast_id) && frame_len >= 7'd3;
               dlen = (frame_len >= 7'd3) ? frame_len - 7'd3 : 7'd0;
               verdict.target_id = tgt;
               verdict.sender_id = snd;
               remaining = dlen;
               if (ok) begin
                  verdict.kind        = rxfhf_pkg::KIND_ACCEPT;
                  verdict.is_ack      = b[rxfhf_pkg::CTL_ACK_SENT_BIT];
                  verdict.wants_ack   = b[rxfhf_pkg::CTL_ACK_REQ_BIT];
                  verdict.data_length = dlen[5:0];
                  verdict.last        = (dlen == 7'd0);
                  discarding = 1'b0;
               end else begin
                  verdict.kind = rxfhf_pkg::KIND_REJECT;
                  verdict.last = 1'b1;
                  discarding = 1'b1;
               end
               stage = (remaining == 7'd0) ? rxfhf_pkg::PH_LENGTH : rxfhf_pkg::PH_PAYLOAD;
               if (stage == rxfhf_pkg::PH_LENGTH) discarding = 1'b0;
               awaited.push_back(verdict);
            end
            rxfhf_pkg::PH_PAYLOAD: begin
               was_discarding = discarding;
               fin = (remaining <= 7'd1);
               remaining = fin ? 7'd0 : remaining - 7'd1;
               if (fin) begin
                  stage = rxfhf_pkg::PH_LENGTH;
                  discarding = 1'b0;
               end
               // Drop payload of a rejected frame silently
               if (!was_discarding) begin
                  verdict.kind      = rxfhf_pkg::KIND_PAYLOAD;
                  verdict.data_byte = b;
                  verdict.last      = fin;
                  awaited.push_back(verdict);
               end
            end
            default: stage = rxfhf_pkg::PH_LENGTH;
         endcase
      endfunction

      function void match(string field, logic [31:0] want, logic [31:0] seen);
         if (want !== seen) begin
            $error("%s: expected %0h, got %0h", field, want, seen);
            faults++;
         end
      endfunction

      function void check_beat(rxfhf_pkg::rsp_beat_type got);
         rxfhf_pkg::rsp_beat_type want;
         if (awaited.size() == 0) begin
            $error("result beat %0h arrived with none expected", got);
            faults++;
            return;
         end
         want = awaited.pop_front();
         match("kind", 32'(want.kind), 32'(got.kind));
         match("target_id", 32'(want.target_id), 32'(got.target_id));
         match("sender_id", 32'(want.sender_id), 32'(got.sender_id));
         match("is_ack", 32'(want.is_ack), 32'(got.is_ack));
         match("wants_ack", 32'(want.wants_ack), 32'(got.wants_ack));
         match("data_length", 32'(want.data_length), 32'(got.data_length));
         match("data_byte", 32'(want.data_byte), 32'(got.data_byte));
         match("last", 32'(want.last), 32'(got.last));
      endfunction

      function int outstanding();
         return awaited.size();
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   rxfhf_pkg::req_beat_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rxfhf_pkg::rsp_beat_type rsp_data;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [3:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   frame_parse_board board;
   int           bytes_taken;
   int           idle_cycles;
   logic         calm;
   logic [9:0]   cur_node;
   logic [9:0]   cur_bcast;

   radio_rx_frame_header_filter dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Sample every handshake at the rising edge and watch for a hung run
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            board.parse_byte(req_data);
            bytes_taken++;
         end
         if (rsp_valid && !rsp_stall) board.check_beat(rsp_data);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            board.write_register(csr_paddr[3:2], csr_pwdata);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Receiver back-pressure: runs of stall and flow, mostly short
   initial begin : rsp_backpressure
      int run_left;
      int r;
      run_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (calm) begin
            rsp_stall = 1'b0;
         end else if (run_left > 0) begin
            run_left--;
         end else begin
            r = $urandom_range(0, 99);
            rsp_stall = (r < 35);
            if (rsp_stall)
               run_left = (r < 3) ? $urandom_range(10, 30) : $urandom_range(0, 3);
            else
               run_left = $urandom_range(0, 6);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   // Bytes after the length byte that a frame of this length byte carries
   function automatic int frame_span(logic [7:0] len);
      int clamped;
      clamped = (int'(len) > MAX_LEN) ? MAX_LEN : int'(len);
      return 3 + ((clamped >= 3) ? clamped - 3 : 0);
   endfunction

   // Present one beat at a falling edge and hold it until taken
   task automatic send_byte(input logic [7:0] b, input logic start);
      int gap;
      req_data.fifo_byte   = b;
      req_data.frame_start = start;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) begin
            req_data = rxfhf_pkg::req_beat_type'(9'($urandom));
            @(negedge clock);
         end
      end
   endtask

   // Send a length byte and then the first count bytes of header and payload
   task automatic send_frame(input logic [7:0] len, input logic [9:0] tgt,
                             input logic [9:0] snd, input logic [3:0] ctl_hi,
                             input int count);
      logic [7:0] ctl;
      logic [7:0] b;
      ctl = {ctl_hi, tgt[9:8], snd[9:8]};
      send_byte(len, 1'b1);
      for (int i = 0; i < count; i++) begin
         b = (i == 0) ? tgt[7:0] : (i == 1) ? snd[7:0] : (i == 2) ? ctl : 8'($urandom);
         send_byte(b, 1'b0);
      end
   endtask

   task automatic send_random_frame();
      int         r;
      int         span;
      logic [7:0] len;
      logic [9:0] tgt;
      r = $urandom_range(0, 99);
      if (r < 10)      len = 8'($urandom_range(0, 2));
      else if (r < 75) len = 8'($urandom_range(3, 12));
      else if (r < 90) len = 8'($urandom_range(13, 66));
      else             len = 8'($urandom_range(67, 255));
      r = $urandom_range(0, 99);
      tgt = (r < 40) ? cur_node : (r < 65) ? cur_bcast : 10'($urandom);
      span = frame_span(len);
      r = $urandom_range(0, 99);
      // Cut some frames short so that the next length byte abandons them
      if (r < 12) span = $urandom_range(0, span - 1);
      send_frame(len, tgt, 10'($urandom), 4'($urandom), span);
      // Scatter stray bytes between complete frames
      if (r >= 12 && r < 20)
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
   endtask

   // Lower valid and wait until every predicted beat has come out
   task automatic wait_drained(input int settle);
      req_valid = 1'b0;
      while (board.outstanding() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // Reprogram all three registers once the block has gone quiet
   task automatic configure(input logic [9:0] node, input logic [9:0] bcast,
                            input logic spy);
      wait_drained(SETTLE);
      csr_write(rxfhf_pkg::REG_NODE_ADDRESS, {22'($urandom), node});
      csr_write(rxfhf_pkg::REG_BROADCAST_ADDRESS, {22'($urandom), bcast});
      csr_write(rxfhf_pkg::REG_SPY_MODE, {31'($urandom), spy});
      cur_node  = node;
      cur_bcast = bcast;
   endtask

   initial begin : stimulus
      int goal;
      board       = new();
      bytes_taken = 0;
      idle_cycles = 0;
      calm        = 1'b0;
      cur_node    = rxfhf_pkg::NODE_ADDRESS_RESET;
      cur_bcast   = rxfhf_pkg::BROADCAST_ADDRESS_RESET;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: stray byte, abandoned frame, accept with no payload,
      // accept with payload and both ack flags, short length, rejected target
      send_byte(8'hFF, 1'b0);
      send_byte(8'd9, 1'b1);
      send_byte(8'h12, 1'b0);
      send_frame(8'd3, 10'd255, 10'd0, 4'h0, 3);
      send_frame(8'd5, 10'd0, 10'h3FF, 4'hC, 5);
      send_frame(8'd2, 10'd255, 10'h2AA, 4'h3, 3);
      send_frame(8'd4, 10'h3FF, 10'h155, 4'hF, 4);

      // Random frames under a series of register settings, extremes first
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: configure(10'h3FF, 10'h000, 1'b0);
            1: configure(10'h000, 10'h3FF, 1'b1);
            2: configure(10'($urandom), 10'($urandom), 1'b0);
            3: configure(10'($urandom), 10'($urandom), 1'b1);
            default: configure(10'($urandom), 10'($urandom), 1'($urandom));
         endcase
         goal = bytes_taken + PHASE_BYTES;
         while (bytes_taken < goal) begin
            if ($urandom_range(0, 29) == 0) calm = !calm;
            send_random_frame();
         end
      end

      calm = 1'b0;
      wait_drained(8);
      if (board.faults == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/rxfhf_pkg.sv
design/radio_rx_frame_header_filter.sv
verif/testbench.sv
